[rtl/a2be_pkg.sv]
// Package with the braille cell table, symbol codes and shared types of the encoder.
package a2be_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_WINDOW_START  = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  // Symbols inserted ahead of capitals and digits.
  localparam logic [7:0] CAPITAL_SYMBOL = 8'd44;
  localparam logic [7:0] NUMBER_SYMBOL  = 8'd35;

  localparam int unsigned CELL_W  = 6;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned REG_W   = 16;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [INDEX_W-1:0] cell_index_t;

  // One pending result.
  typedef struct packed {
    cell_t       dots;
    cell_index_t index;
    logic        last;
  } cell_slot_t;

  // Braille ASCII table for character codes 32 to 95.
  localparam cell_t CELL_TABLE [64] = '{
    6'd0,  6'd46, 6'd16, 6'd60, 6'd43, 6'd41, 6'd47, 6'd4,
    6'd55, 6'd62, 6'd33, 6'd44, 6'd32, 6'd36, 6'd40, 6'd12,
    6'd52, 6'd2,  6'd6,  6'd18, 6'd50, 6'd34, 6'd22, 6'd54,
    6'd38, 6'd20, 6'd49, 6'd48, 6'd35, 6'd63, 6'd28, 6'd57,
    6'd8,  6'd1,  6'd3,  6'd9,  6'd25, 6'd17, 6'd11, 6'd27,
    6'd19, 6'd10, 6'd26, 6'd5,  6'd7,  6'd13, 6'd29, 6'd21,
    6'd15, 6'd31, 6'd23, 6'd14, 6'd30, 6'd37, 6'd39, 6'd58,
    6'd45, 6'd61, 6'd53, 6'd42, 6'd51, 6'd59, 6'd24, 6'd56
  };

  // Lowercase letters fold to uppercase; codes outside 32..95 give a blank cell.
  function automatic cell_t symbol_cell(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] off;
    u = c;
    if (c > 8'd96 && c < 8'd123) begin
      u = c - 8'd32;
    end
    off = u - 8'd32;
    if (u >= 8'd32 && u < 8'd96) begin
      return CELL_TABLE[off[5:0]];
    end
    return '0;
  endfunction

  // Punctuation written with lower-cell digit patterns.
  function automatic logic [7:0] remap_punct(input logic [7:0] c);
    case (c)
      8'd34:   return 8'd48;
      8'd44:   return 8'd49;
      8'd59:   return 8'd50;
      8'd58:   return 8'd51;
      8'd46:   return 8'd52;
      8'd33:   return 8'd54;
      8'd40:   return 8'd55;
      8'd41:   return 8'd55;
      8'd63:   return 8'd56;
      default: return c;
    endcase
  endfunction

endpackage

[rtl/ascii_to_braille_encoder_unit.sv]
// Top level of the ASCII to six-dot braille encoder.
//
//   Port group | Direction | Handshake         | Beat contents
//   in_        | input     | in_valid/in_ready | ascii_char, first_char
//   out_       | output    | out_valid/out_ready | cell_res, cell_index, run_last
//   cfg_       | input     | cfg_we            | cfg_index, cfg_wdata
//
// A character's cells, two for a capital or digit (sign plus symbol), hold the result
// register until the last leaves; the single output port, which delivers one cell per
// cycle while out_ready is high, sets the pace. An input beat passes the input register
// and then the result register. Reset is synchronous and active low; it clears the cell
// position and loads window_start 0 and window_length 65535. A stalled output holds its
// pair of cells while the input register may still take one more beat.
module ascii_to_braille_encoder_unit
  import a2be_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_ascii_char,
  input  logic                    in_first_char,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CELL_W-1:0]       out_cell_res,
  output logic [INDEX_W-1:0]      out_cell_index,
  output logic                    out_run_last,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [REG_W-1:0]        cfg_wdata
);

  // Comparisons of a position against the 16-bit window run at the wider of the two.
  localparam int unsigned CMP_W = (POSITION_BITS > REG_W) ? POSITION_BITS : REG_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Configuration registers.
  logic [REG_W-1:0] win_start_r;
  logic [REG_W-1:0] win_length_r;

  // Input register.
  logic       a_valid_r;
  logic [7:0] a_char_r;
  logic       a_first_r;

  // Running cell position of the current string.
  logic [POSITION_BITS-1:0] cell_position_r;
  logic [POSITION_BITS-1:0] cell_position_nxt;

  // Result register: two slots, slot 0 goes out first.
  cell_slot_t slot0_r, slot1_r;
  logic       v0_r, v1_r;

  logic in_fire, out_fire, load;

  // Per-character decode.
  logic                     two_cells;
  logic [7:0]               sym0, sym1;
  logic [POSITION_BITS-1:0] p0, p1;
  logic [CMP_W-1:0]         diff0, diff1;
  logic                     emit0, emit1;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // The result register takes a new pair when it is empty or drains its last cell now.
  assign load     = a_valid_r && (!(v0_r || v1_r) || (out_ready && (v0_r ^ v1_r)));
  assign in_ready = !a_valid_r || load;

  always_comb begin
    two_cells = 1'b0;
    sym0      = remap_punct(a_char_r);
    sym1      = '0;
    if (a_char_r > 8'd64 && a_char_r < 8'd91) begin
      two_cells = 1'b1;
      sym0      = CAPITAL_SYMBOL;
      sym1      = a_char_r | 8'd32;
    end else if (a_char_r > 8'd47 && a_char_r < 8'd58) begin
      two_cells = 1'b1;
      sym0      = NUMBER_SYMBOL;
      sym1      = a_char_r;
    end
  end

  // Positions of the two cells; the counter sticks at all ones.
  always_comb begin
    p0 = a_first_r ? '0 : cell_position_r;
    p1 = (p0 == POS_MAX) ? POS_MAX : p0 + POSITION_BITS'(1);
    if (two_cells) begin
      cell_position_nxt = (p1 == POS_MAX) ? POS_MAX : p1 + POSITION_BITS'(1);
    end else begin
      cell_position_nxt = p1;
    end
  end

  // Window test: inside when at or past the start and less than length beyond it.
  always_comb begin
    diff0 = CMP_W'(p0) - CMP_W'(win_start_r);
    diff1 = CMP_W'(p1) - CMP_W'(win_start_r);
    emit0 = (p0 != POS_MAX) && (CMP_W'(p0) >= CMP_W'(win_start_r)) &&
            (diff0 < CMP_W'(win_length_r));
    emit1 = two_cells && (p1 != POS_MAX) && (CMP_W'(p1) >= CMP_W'(win_start_r)) &&
            (diff1 < CMP_W'(win_length_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r  <= '0;
      win_length_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_START:  win_start_r  <= cfg_wdata;
        REG_WINDOW_LENGTH: win_length_r <= cfg_wdata;
        default:           win_start_r  <= win_start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r       <= 1'b0;
      cell_position_r <= '0;
      v0_r            <= 1'b0;
      v1_r            <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (load) begin
        a_valid_r <= 1'b0;
      end
      if (load) begin
        cell_position_r <= cell_position_nxt;
        v0_r            <= emit0;
        v1_r            <= emit1;
      end else if (out_fire) begin
        // Slot 0 leaves first; slot 1 follows on the next beat.
        if (v0_r) begin
          v0_r <= 1'b0;
        end else begin
          v1_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_char_r  <= in_ascii_char;
      a_first_r <= in_first_char;
    end
    if (load) begin
      slot0_r.dots  <= symbol_cell(sym0);
      slot0_r.index <= diff0[INDEX_W-1:0];
      slot0_r.last  <= !emit1;
      slot1_r.dots  <= symbol_cell(sym1);
      slot1_r.index <= diff1[INDEX_W-1:0];
      slot1_r.last  <= 1'b1;
    end
  end

  assign out_valid      = v0_r || v1_r;
  assign out_cell_res   = v0_r ? slot0_r.dots  : slot1_r.dots;
  assign out_cell_index = v0_r ? slot0_r.index : slot1_r.index;
  assign out_run_last   = v0_r ? slot0_r.last  : slot1_r.last;

`ifndef NO_ASSERTIONS
  // A saturated position stays saturated until a new string starts.
  a_pos_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_position_r == POS_MAX && !(load && a_first_r)) |=> cell_position_r == POS_MAX)
    else $error("cell position left saturation without a new string");

  // With both cells pending, the first one is not marked last.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && v1_r) |-> !slot0_r.last)
    else $error("first of two pending cells marked last");

  // Two pending cells sit at neighboring window positions.
  a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && v1_r) |-> slot1_r.index == slot0_r.index + INDEX_W'(1))
    else $error("pending cell pair not adjacent");
`endif

endmodule

[tb/ascii_to_braille_encoder_unit_test.sv]
// Self-checking testbench of the ASCII to braille encoder, with its own cell predictor.
module ascii_to_braille_encoder_unit_test
  import a2be_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT   = 4000;
  // Extra cycles after the last expected cell, to let cell-less characters clear.
  localparam int unsigned SETTLE_CYCLES = 10;
  // Length of the one long receiver hold-off.
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int          NUM_PHASES    = 16;
  localparam int          HOLD_PHASE    = 1;

  localparam logic [15:0] POS_SAT = 16'hFFFF;

  // Dot patterns of the Braille ASCII set, character codes 32 to 95.
  localparam cell_t DOTS [64] = '{
    6'd0,  6'd46, 6'd16, 6'd60, 6'd43, 6'd41, 6'd47, 6'd4,
    6'd55, 6'd62, 6'd33, 6'd44, 6'd32, 6'd36, 6'd40, 6'd12,
    6'd52, 6'd2,  6'd6,  6'd18, 6'd50, 6'd34, 6'd22, 6'd54,
    6'd38, 6'd20, 6'd49, 6'd48, 6'd35, 6'd63, 6'd28, 6'd57,
    6'd8,  6'd1,  6'd3,  6'd9,  6'd25, 6'd17, 6'd11, 6'd27,
    6'd19, 6'd10, 6'd26, 6'd5,  6'd7,  6'd13, 6'd29, 6'd21,
    6'd15, 6'd31, 6'd23, 6'd14, 6'd30, 6'd37, 6'd39, 6'd58,
    6'd45, 6'd61, 6'd53, 6'd42, 6'd51, 6'd59, 6'd24, 6'd56
  };

  // The punctuation marks that are written with lower-cell digit patterns.
  localparam logic [7:0] PUNCT [9] = '{
    8'h22, 8'h2C, 8'h3B, 8'h3A, 8'h2E, 8'h21, 8'h28, 8'h29, 8'h3F
  };

  // Window settings visited first: full window, narrow windows, the empty window,
  // a window that starts at the saturated position, and single-cell windows.
  localparam logic [15:0] WIN_START [8] = '{
    16'd0, 16'd3, 16'd0, 16'd65535, 16'd1, 16'd2, 16'd0, 16'd65534
  };
  localparam logic [15:0] WIN_LEN [8] = '{
    16'd65535, 16'd5, 16'd0, 16'd65535, 16'd1, 16'd3, 16'd1, 16'd2
  };

  // One row of the directed part. Where typed is set, the cells (one or two) and
  // the index of the first one are written out by hand.
  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        typed;
    logic [1:0]  n;
    cell_t       c0;
    cell_t       c1;
    cell_index_t idx;
  } char_row_t;

  // These rows run with the reset window (start 0, length 65535).
  localparam char_row_t ROWS [26] = '{
    '{8'h41, 1'b1, 1'b1, 2'd2, 6'd32, 6'd1,  16'd0},   // capital A
    '{8'h7A, 1'b0, 1'b1, 2'd1, 6'd53, 6'd0,  16'd2},   // lowercase z
    '{8'h30, 1'b0, 1'b1, 2'd2, 6'd60, 6'd52, 16'd3},   // digit 0
    '{8'h39, 1'b0, 1'b1, 2'd2, 6'd60, 6'd20, 16'd5},   // digit 9
    '{8'h00, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd7},   // control code
    '{8'hFF, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd8},   // top code
    '{8'h60, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd9},   // grave accent, unmapped
    '{8'h7B, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd10},  // open brace, unmapped
    '{8'h7F, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd11},
    '{8'h80, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd12},
    '{8'h22, 1'b0, 1'b1, 2'd1, 6'd52, 6'd0,  16'd13},  // double quote
    '{8'h2C, 1'b0, 1'b1, 2'd1, 6'd2,  6'd0,  16'd14},  // comma
    '{8'h3B, 1'b0, 1'b1, 2'd1, 6'd6,  6'd0,  16'd15},  // semicolon
    '{8'h3A, 1'b0, 1'b1, 2'd1, 6'd18, 6'd0,  16'd16},  // colon
    '{8'h2E, 1'b0, 1'b1, 2'd1, 6'd50, 6'd0,  16'd17},  // period
    '{8'h21, 1'b0, 1'b1, 2'd1, 6'd22, 6'd0,  16'd18},  // exclamation mark
    '{8'h28, 1'b0, 1'b1, 2'd1, 6'd54, 6'd0,  16'd19},  // open parenthesis
    '{8'h29, 1'b0, 1'b1, 2'd1, 6'd54, 6'd0,  16'd20},  // close parenthesis
    '{8'h3F, 1'b0, 1'b1, 2'd1, 6'd38, 6'd0,  16'd21},  // question mark
    '{8'h20, 1'b0, 1'b1, 2'd1, 6'd0,  6'd0,  16'd22},  // space
    '{8'h5A, 1'b1, 1'b1, 2'd2, 6'd32, 6'd53, 16'd0},   // capital Z starts a new string
    '{8'h5F, 1'b0, 1'b1, 2'd1, 6'd56, 6'd0,  16'd2},   // underscore, last table entry
    '{8'h40, 1'b0, 1'b1, 2'd1, 6'd8,  6'd0,  16'd3},   // at sign, just below the capitals
    '{8'h5B, 1'b0, 1'b1, 2'd1, 6'd42, 6'd0,  16'd4},   // open bracket, just above them
    '{8'h61, 1'b0, 1'b1, 2'd1, 6'd1,  6'd0,  16'd5},   // lowercase a
    '{8'h4D, 1'b0, 1'b0, 2'd0, 6'd0,  6'd0,  16'd0}    // capital M, predicted
  };

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [7:0]        in_ascii_char  = '0;
  logic              in_first_char  = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CELL_W-1:0] out_cell_res;
  logic [INDEX_W-1:0] out_cell_index;
  logic              out_run_last;
  logic              cfg_we         = 1'b0;
  logic              cfg_index      = REG_WINDOW_START;
  logic [REG_W-1:0]  cfg_wdata      = '0;

  // Predictor state: the running cell position and the window registers.
  logic [15:0] char_pos     = '0;
  logic [15:0] win_start    = 16'd0;
  logic [15:0] win_len      = 16'd65535;

  // Cells predicted but not yet seen on the output channel, oldest first.
  cell_slot_t  pending_cells [$];

  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          src_steady   = 1'b0;
  bit          sink_steady  = 1'b0;
  bit          sink_hold_req = 1'b0;

  ascii_to_braille_encoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ascii_char  (in_ascii_char),
    .in_first_char  (in_first_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_res   (out_cell_res),
    .out_cell_index (out_cell_index),
    .out_run_last   (out_run_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Idle stretches: mostly none or short ones, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random character, weighted toward the classes that expand or get remapped.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return PUNCT[$urandom_range(0, 8)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Punctuation shares its cells with the lower-cell digit characters.
  function automatic logic [7:0] punct_to_digit(input logic [7:0] c);
    case (c)
      8'h22: return 8'h30;
      8'h2C: return 8'h31;
      8'h3B: return 8'h32;
      8'h3A: return 8'h33;
      8'h2E: return 8'h34;
      8'h21: return 8'h36;
      8'h28: return 8'h37;
      8'h29: return 8'h37;
      8'h3F: return 8'h38;
      default: return c;
    endcase
  endfunction

  // Dot pattern of one symbol; lowercase folds onto uppercase, anything outside
  // the table is a blank cell.
  function automatic cell_t dots_of(input logic [7:0] s);
    logic [7:0] u;
    logic [7:0] off;
    u = (s >= 8'h61 && s <= 8'h7A) ? s - 8'd32 : s;
    off = u - 8'h20;
    if (u >= 8'h20 && u <= 8'h5F) begin
      return DOTS[off[5:0]];
    end
    return '0;
  endfunction

  // Expands one character into its cells, advances the cell position and keeps
  // only the cells that fall inside the window. Returns how many were kept.
  function automatic int encode_char(input logic [7:0] c, input logic first,
                                     output cell_slot_t res [2]);
    logic [7:0]  sym [2];
    logic [15:0] p;
    int          nsym;
    int          nres;
    nres = 0;
    res[0] = '0;
    res[1] = '0;
    if (first) begin
      char_pos = '0;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      sym[0] = CAPITAL_SYMBOL;
      sym[1] = c | 8'h20;
      nsym = 2;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      sym[0] = NUMBER_SYMBOL;
      sym[1] = c;
      nsym = 2;
    end else begin
      sym[0] = punct_to_digit(c);
      sym[1] = '0;
      nsym = 1;
    end
    for (int k = 0; k < nsym; k++) begin
      p = char_pos;
      // The all-ones position is a sink: cells counted there never come out.
      if (p != POS_SAT && p >= win_start && (p - win_start) < win_len) begin
        res[nres].dots  = dots_of(sym[k]);
        res[nres].index = p - win_start;
        res[nres].last  = 1'b0;
        nres++;
      end
      if (p != POS_SAT) begin
        char_pos = p + 16'd1;
      end
    end
    if (nres > 0) begin
      res[nres-1].last = 1'b1;
    end
    return nres;
  endfunction

  // Appends one predicted cell behind the ones already waiting.
  task automatic queue_cell(input cell_slot_t s);
    pending_cells = {pending_cells, s};
  endtask

  // Presents one character beat and returns at the edge that accepts it.
  task automatic offer(input logic [7:0] c, input logic first);
    int unsigned gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_ascii_char <= c;
    in_first_char <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_char(input logic [7:0] c, input logic first);
    cell_slot_t got [2];
    int         n;
    offer(c, first);
    n = encode_char(c, first, got);
    for (int k = 0; k < n; k++) begin
      queue_cell(got[k]);
    end
  endtask

  // Random strings: mostly short, some long, and an occasional early restart.
  task automatic run_strings(input int count);
    int   left;
    logic first;
    left = 0;
    repeat (count) begin
      if (left == 0 || $urandom_range(0, 49) == 0) begin
        first = 1'b1;
        left  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      end else begin
        first = 1'b0;
      end
      send_char(pick_char(), first);
      left--;
    end
  endtask

  // Writes both window registers on back-to-back cycles; only called while idle.
  task automatic write_window(input logic [15:0] start, input logic [15:0] length);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_wdata <= length;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_start = start;
    win_len   = length;
  endtask

  // Waits for every predicted cell, then lets any cell-less character drain.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: ready most of the time, with random stalls, and one long hold-off
  // on request that lets the block fill up and push back on its input.
  initial begin : sink_proc
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left    = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Output checker: every accepted cell beat must match the oldest prediction.
  always @(posedge clk) begin
    cell_slot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell beat: cell %0d index %0d last %0b",
                 $realtime, out_cell_res, out_cell_index, out_run_last);
      end else begin
        want = pending_cells.pop_front();
        if (out_cell_res !== want.dots) begin
          errors++;
          $display("%0t: cell_res mismatch: expected %0d actual %0d",
                   $realtime, want.dots, out_cell_res);
        end
        if (out_cell_index !== want.index) begin
          errors++;
          $display("%0t: cell_index mismatch: expected %0d actual %0d",
                   $realtime, want.index, out_cell_index);
        end
        if (out_run_last !== want.last) begin
          errors++;
          $display("%0t: run_last mismatch: expected %0b actual %0b",
                   $realtime, want.last, out_run_last);
        end
      end
    end
  end

  // Watchdog: a stretch with no beat on either channel means the block hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d cells still due",
                 $realtime, quiet_cycles, pending_cells.size());
        $display("ascii_to_braille_encoder_unit_test: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cell_slot_t  got [2];
    cell_slot_t  slot;
    int          n;
    logic [15:0] ws;
    logic [15:0] wl;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset window. Typed rows replace the prediction
    // with the hand-written cells, but the predictor still tracks the position.
    foreach (ROWS[i]) begin
      offer(ROWS[i].ch, ROWS[i].first);
      n = encode_char(ROWS[i].ch, ROWS[i].first, got);
      if (ROWS[i].typed) begin
        for (int k = 0; k < int'(ROWS[i].n); k++) begin
          slot.dots  = (k == 0) ? ROWS[i].c0 : ROWS[i].c1;
          slot.index = ROWS[i].idx + 16'(k);
          slot.last  = (k == int'(ROWS[i].n) - 1);
          queue_cell(slot);
        end
      end else begin
        for (int k = 0; k < n; k++) begin
          queue_cell(got[k]);
        end
      end
    end
    drain_outputs();

    // Random phases: the fixed window settings first, then random windows, mostly small.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 8) begin
        ws = WIN_START[ph];
        wl = WIN_LEN[ph];
      end else begin
        ws = 16'($urandom_range(0, 24));
        wl = ($urandom_range(0, 5) == 0) ? 16'd65535 : 16'($urandom_range(1, 40));
      end
      write_window(ws, wl);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if (ph == HOLD_PHASE) begin
        // The sender keeps offering beats while the receiver sits out a long stall.
        src_steady    = 1'b1;
        sink_hold_req = 1'b1;
      end
      run_strings((wl == 16'd0 || ws == 16'd65535) ? 40 : 110);
      drain_outputs();
    end

    // Closing stretch back under the full window with the usual traffic mix.
    write_window(16'd0, 16'd65535);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    run_strings(104);
    drain_outputs();

    if (errors == 0) begin
      $display("ascii_to_braille_encoder_unit_test: clean");
    end else begin
      $display("ascii_to_braille_encoder_unit_test: errors");
    end
    $finish;
  end

endmodule
